### src/fpes_pkg.sv
package fpes_pkg;

	// Input command codes.
	localparam logic [1:0] CMD_ERASE   = 2'd0;
	localparam logic [1:0] CMD_PROGRAM = 2'd1;
	localparam logic [1:0] CMD_STATUS  = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_ERASE_LIMIT   = 2'd0;
	localparam logic [1:0] REG_PROGRAM_LIMIT = 2'd1;

	// Flash command words and status masks.
	localparam logic [15:0] FL_CLEAR_STATUS = 16'h5050;
	localparam logic [15:0] FL_ERASE_SETUP  = 16'h2020;
	localparam logic [15:0] FL_ERASE_CONFIRM = 16'hD0D0;
	localparam logic [15:0] FL_READ_STATUS  = 16'h7070;
	localparam logic [15:0] FL_WORD_PROGRAM = 16'h4040;
	localparam logic [15:0] FL_READ_ARRAY   = 16'hFFFF;
	localparam logic [7:0]  ST_READY        = 8'h80;
	localparam logic [7:0]  ST_ERASE_MASK   = 8'hE8;
	localparam logic [7:0]  ST_PROGRAM_MASK = 8'h98;

	// Reset values of the poll limits.
	localparam logic [22:0] ERASE_LIMIT_RESET   = 23'h640000;
	localparam logic [15:0] PROGRAM_LIMIT_RESET = 16'h1000;

	// Shape of a burst of results produced by one input item.
	typedef enum logic [2:0] {
		B_NONE,
		B_START,
		B_READ,
		B_FINISH,
		B_DONE
	} burst_kind_t;

	typedef struct packed {
		burst_kind_t btype;
		logic [23:0] addr;
		logic [15:0] d1;
		logic [15:0] d2;
		logic [7:0]  code;
	} burst_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [23:0] address;
		logic [15:0] data;
		logic        last_word;
		logic        test_write;
	} item_t;

endpackage

### src/flash_program_erase_sequencer_unit.sv
// Flash program and erase sequencer.
// The input stream carries requests: block erase starts, program words and
// status replies read back from the flash. The output stream carries flash
// bus writes, status read requests and a done result with a completion code.
// The user must write the two poll limits through the configuration channel
// only while the block is idle; the block itself has no check for this. cfg_ready is always high.
// An accepted request is held in an input register and decoded there; its
// burst is then loaded into the result emitter, which offers the first result.
// Throughput: one result per cycle while the receiver is ready. A request
// produces five results for an erase start or a programmed word, three for a
// completion, one for a poll or the end of a dry run. The result emitter steps
// through one burst and loads the next one as its last result is taken.
// Requests with no result (dry run words before the last, ignored commands) leave the emitter idle.
// When the receiver stalls, the current result holds and one further request
// waits decoded in the input register; s_axis_tready falls until the burst
// drains.
// Reset clears the sequencer to idle with the voltage off and loads the
// default poll limits; there is no clearing pass.
module flash_program_erase_sequencer_unit import fpes_pkg::*; #(
	parameter int ADDR_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // address[23:0], data[39:24], test_write[40]
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	input  logic        s_axis_tlast,  // last_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // bus_address[23:0], bus_data[39:24],
	                                   // code[47:40], vpp_enable[48]
	output logic [1:0]  m_axis_tuser,  // kind[1:0]
	output logic        m_axis_tlast,  // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_data
);

	item_t       item_s1;
	logic        valid_s1;
	logic        ld_ready;
	logic        commit;
	burst_t      burst;
	logic [23:0] bus_address;
	logic [15:0] bus_data;
	logic [7:0]  code;
	logic        vpp_enable;

	assign cfg_ready     = 1'b1;
	assign commit        = valid_s1 && ld_ready;
	assign s_axis_tready = !valid_s1 || ld_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.cmd        <= s_axis_tuser;
			item_s1.address    <= s_axis_tdata[23:0];
			item_s1.data       <= s_axis_tdata[39:24];
			item_s1.last_word  <= s_axis_tlast;
			item_s1.test_write <= s_axis_tdata[40];
		end
	end

	fpes_ctrl #(
		.ADDR_BITS(ADDR_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.commit   (commit),
		.item     (item_s1),
		.burst    (burst)
	);

	fpes_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld_valid   (valid_s1),
		.ld_ready   (ld_ready),
		.burst      (burst),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.kind       (m_axis_tuser),
		.bus_address(bus_address),
		.bus_data   (bus_data),
		.code       (code),
		.vpp_enable (vpp_enable),
		.last       (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, vpp_enable, code, bus_data, bus_address};

endmodule

### src/fpes_ctrl.sv
module fpes_ctrl import fpes_pkg::*; #(
	parameter int ADDR_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_data,
	input  logic        commit,
	input  item_t       item,
	output burst_t      burst
);

	typedef enum logic [3:0] {
		PH_IDLE       = 4'b0001,
		PH_ERASE_POLL = 4'b0010,
		PH_WORD_POLL  = 4'b0100,
		PH_WORD_READY = 4'b1000
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [22:0]            poll_count_q, poll_count_d;
	logic [ADDR_BITS-1:0]   start_address_q, start_address_d;
	logic [ADDR_BITS-1:0]   word_address_q, word_address_d;
	logic                   final_pending_q, final_pending_d;
	logic                   vpp_on_q, vpp_on_d;
	logic [22:0]            erase_limit_q;
	logic [15:0]            program_limit_q;

	logic [ADDR_BITS+23:0]  in_wide;
	logic [ADDR_BITS-1:0]   in_addr;
	logic [ADDR_BITS-1:0]   sel_addr;
	logic [ADDR_BITS+23:0]  out_wide;
	logic [ADDR_BITS-1:0]   waddr;
	logic                   eff_vpp;
	logic [23:0]            pc_inc;
	logic [23:0]            erase_lim_eff;
	logic [23:0]            program_lim_eff;
	logic [7:0]             st_erase;

	// Fit the 24-bit address field to the internal address width.
	assign in_wide  = {{ADDR_BITS{1'b0}}, item.address};
	assign in_addr  = in_wide[ADDR_BITS-1:0];
	assign out_wide = {24'd0, sel_addr};

	assign pc_inc          = {1'b0, poll_count_q} + 24'd1;
	assign erase_lim_eff   = (erase_limit_q == 23'd0) ? 24'd1 : {1'b0, erase_limit_q};
	assign program_lim_eff = (program_limit_q == 16'd0) ? 24'd1 : {8'd0, program_limit_q};
	assign st_erase        = item.data[7:0] & ST_ERASE_MASK;

	assign waddr   = (phase_q == PH_IDLE) ? in_addr : word_address_q;
	assign eff_vpp = (phase_q == PH_IDLE) ? !item.test_write : vpp_on_q;

	// Next state and the burst of results for the item in the input register.
	always_comb begin
		phase_d         = phase_q;
		poll_count_d    = poll_count_q;
		start_address_d = start_address_q;
		word_address_d  = word_address_q;
		final_pending_d = final_pending_q;
		vpp_on_d        = vpp_on_q;
		sel_addr        = start_address_q;
		burst.btype     = B_NONE;
		burst.d1        = FL_ERASE_SETUP;
		burst.d2        = FL_ERASE_CONFIRM;
		burst.code      = 8'd0;
		if (item.cmd == CMD_ERASE && phase_q == PH_IDLE) begin
			vpp_on_d        = 1'b1;
			start_address_d = in_addr;
			word_address_d  = in_addr;
			sel_addr        = in_addr;
			burst.btype     = B_START;
			poll_count_d    = 23'd0;
			phase_d         = PH_ERASE_POLL;
		end else if (item.cmd == CMD_PROGRAM &&
				(phase_q == PH_IDLE || phase_q == PH_WORD_READY)) begin
			if (phase_q == PH_IDLE) begin
				start_address_d = in_addr;
			end
			vpp_on_d = eff_vpp;
			sel_addr = waddr;
			if (!eff_vpp) begin
				// Dry run: every status counts as ready at once.
				if (item.last_word) begin
					burst.btype     = B_DONE;
					phase_d         = PH_IDLE;
					final_pending_d = 1'b0;
					word_address_d  = waddr;
				end else begin
					word_address_d = waddr + ADDR_BITS'(2);
					phase_d        = PH_WORD_READY;
				end
			end else begin
				word_address_d  = waddr;
				burst.btype     = B_START;
				burst.d1        = FL_WORD_PROGRAM;
				burst.d2        = item.data;
				final_pending_d = item.last_word;
				poll_count_d    = 23'd0;
				phase_d         = PH_WORD_POLL;
			end
		end else if (item.cmd == CMD_STATUS && phase_q == PH_ERASE_POLL) begin
			poll_count_d = pc_inc[22:0];
			sel_addr     = start_address_q;
			if (item.data[7] || pc_inc >= erase_lim_eff) begin
				burst.btype     = B_FINISH;
				burst.code      = (st_erase == ST_READY) ? 8'd0 : st_erase;
				vpp_on_d        = 1'b0;
				phase_d         = PH_IDLE;
				final_pending_d = 1'b0;
				poll_count_d    = 23'd0;
			end else begin
				burst.btype = B_READ;
			end
		end else if (item.cmd == CMD_STATUS && phase_q == PH_WORD_POLL) begin
			poll_count_d = pc_inc[22:0];
			sel_addr     = word_address_q;
			if (item.data[7]) begin
				if (final_pending_q) begin
					sel_addr        = start_address_q;
					burst.btype     = B_FINISH;
					burst.code      = ((item.data[7:0] & ST_PROGRAM_MASK) == ST_READY) ?
						8'd0 : item.data[7:0];
					vpp_on_d        = 1'b0;
					phase_d         = PH_IDLE;
					final_pending_d = 1'b0;
					poll_count_d    = 23'd0;
				end else begin
					word_address_d = word_address_q + ADDR_BITS'(2);
					poll_count_d   = 23'd0;
					phase_d        = PH_WORD_READY;
				end
			end else if (pc_inc >= program_lim_eff) begin
				burst.btype     = B_FINISH;
				burst.code      = item.data[7:0];
				vpp_on_d        = 1'b0;
				phase_d         = PH_IDLE;
				final_pending_d = 1'b0;
				poll_count_d    = 23'd0;
			end else begin
				burst.btype = B_READ;
			end
		end
		burst.addr = out_wide[23:0];
	end

	// Sequencer state advances only when the item hands its burst over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			poll_count_q    <= 23'd0;
			start_address_q <= '0;
			word_address_q  <= '0;
			final_pending_q <= 1'b0;
			vpp_on_q        <= 1'b0;
		end else if (commit) begin
			phase_q         <= phase_d;
			poll_count_q    <= poll_count_d;
			start_address_q <= start_address_d;
			word_address_q  <= word_address_d;
			final_pending_q <= final_pending_d;
			vpp_on_q        <= vpp_on_d;
		end
	end

	// Poll limit registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_limit_q   <= ERASE_LIMIT_RESET;
			program_limit_q <= PROGRAM_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ERASE_LIMIT:   erase_limit_q   <= cfg_data;
				REG_PROGRAM_LIMIT: program_limit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

endmodule

### src/fpes_emit.sv
module fpes_emit import fpes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ld_valid,
	output logic        ld_ready,
	input  burst_t      burst,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [23:0] bus_address,
	output logic [15:0] bus_data,
	output logic [7:0]  code,
	output logic        vpp_enable,
	output logic        last
);

	burst_t      burst_q;
	logic        busy_q;
	logic [2:0]  idx_q;
	logic [2:0]  last_idx;
	logic        out_fire;

	// Index of the final result of each burst shape.
	always_comb begin
		case (burst_q.btype)
			B_START:  last_idx = 3'd4;
			B_FINISH: last_idx = 3'd2;
			default:  last_idx = 3'd0;
		endcase
	end

	assign out_valid = busy_q;
	assign last      = (idx_q == last_idx);
	assign out_fire  = busy_q && out_ready;
	assign ld_ready  = !busy_q || (out_fire && last);

	// Result fields selected from the held burst and the position in it.
	always_comb begin
		kind     = KIND_WRITE;
		bus_data = 16'd0;
		case (burst_q.btype)
			B_START: begin
				case (idx_q)
					3'd0:    bus_data = FL_CLEAR_STATUS;
					3'd1:    bus_data = burst_q.d1;
					3'd2:    bus_data = burst_q.d2;
					3'd3:    bus_data = FL_READ_STATUS;
					default: kind = KIND_READ;
				endcase
			end
			B_READ: kind = KIND_READ;
			B_FINISH: begin
				if (idx_q == 3'd2) begin
					kind = KIND_DONE;
				end else begin
					bus_data = FL_READ_ARRAY;
				end
			end
			default: kind = KIND_DONE;
		endcase
	end

	assign bus_address = (kind == KIND_DONE) ? 24'd0 : burst_q.addr;
	assign code        = (kind == KIND_DONE) ? burst_q.code : 8'd0;
	assign vpp_enable  = (kind != KIND_DONE);

	// Burst control: load a new burst as the previous one finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (ld_valid && ld_ready) begin
			busy_q <= (burst.btype != B_NONE);
			idx_q  <= 3'd0;
		end else if (out_fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

	// Burst payload.
	always_ff @(posedge clk) begin
		if (ld_valid && ld_ready) begin
			burst_q <= burst;
		end
	end

	// A result in the middle of a burst is followed by the next one.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !last |=> busy_q && idx_q == $past(idx_q) + 3'd1)
		else $error("burst index did not advance");

	// The index never runs past the end of the held burst.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= last_idx)
		else $error("burst index beyond burst length");

	// A finished burst leaves the emitter empty unless a new one loads.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && last && !ld_valid |=> !busy_q)
		else $error("emitter still busy after final result");

endmodule

### bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fpes_pkg::*;

	// Command code that the sequencer does not decode.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int TAIL_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_PRINTED = 40;

	// One bus operation or completion leaving the sequencer.
	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] bus_address;
		logic [15:0] bus_data;
		logic [7:0]  code;
		logic        vpp_enable;
		logic        last;
	} bus_op_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_ERASE_POLL,
		SEQ_WORD_POLL,
		SEQ_WORD_READY
	} seq_phase_t;

	// Tracks the flash command sequence and holds the bus operations still owed.
	class flash_sequence_predictor;
		logic [22:0] erase_limit;
		logic [15:0] program_limit;
		seq_phase_t  phase;
		int          polls;
		logic [23:0] start_addr;
		logic [23:0] word_addr;
		bit          final_word;
		bit          vpp;
		bus_op_t     expected_bus_ops[$];
		int mismatches, requests, ignored, checked;
		int erases_done, programs_done, dry_runs, timeouts;

		function new();
			erase_limit = ERASE_LIMIT_RESET;
			program_limit = PROGRAM_LIMIT_RESET;
			phase = SEQ_IDLE;
			polls = 0;
			start_addr = '0;
			word_addr = '0;
			final_word = 1'b0;
			vpp = 1'b0;
		endfunction

		function void set_reg(logic [1:0] index, logic [22:0] value);
			if (index == REG_ERASE_LIMIT)
				erase_limit = value;
			else if (index == REG_PROGRAM_LIMIT)
				program_limit = value[15:0];
		endfunction

		function void add_op(logic [1:0] kind, logic [23:0] addr, logic [15:0] data,
				logic [7:0] code);
			bus_op_t op;
			op.kind = kind;
			op.bus_address = addr;
			op.bus_data = data;
			op.code = code;
			op.vpp_enable = vpp;
			op.last = 1'b0;
			expected_bus_ops.push_back(op);
		endfunction

		// A zero limit still allows one poll.
		function bit limit_hit(int limit);
			return polls >= ((limit == 0) ? 1 : limit);
		endfunction

		// Back to read-array mode, voltage off, then the completion code.
		function void finish_op(logic [23:0] addr, logic [7:0] code);
			add_op(KIND_WRITE, addr, FL_READ_ARRAY, 8'h00);
			add_op(KIND_WRITE, addr, FL_READ_ARRAY, 8'h00);
			vpp = 1'b0;
			add_op(KIND_DONE, 24'h000000, 16'h0000, code);
			phase = SEQ_IDLE;
			final_word = 1'b0;
			polls = 0;
		endfunction

		// Applies one accepted request; returns 0 when the sequencer ignores it.
		function bit note_request(item_t it);
			int size_at_entry;
			bit taken;
			logic [7:0] code;
			bus_op_t tail_op;
			size_at_entry = expected_bus_ops.size();
			taken = 1'b1;
			requests++;
			if (it.cmd == CMD_ERASE && phase == SEQ_IDLE) begin
				vpp = 1'b1;
				start_addr = it.address;
				word_addr = it.address;
				add_op(KIND_WRITE, it.address, FL_CLEAR_STATUS, 8'h00);
				add_op(KIND_WRITE, it.address, FL_ERASE_SETUP, 8'h00);
				add_op(KIND_WRITE, it.address, FL_ERASE_CONFIRM, 8'h00);
				add_op(KIND_WRITE, it.address, FL_READ_STATUS, 8'h00);
				add_op(KIND_READ, it.address, 16'h0000, 8'h00);
				polls = 0;
				phase = SEQ_ERASE_POLL;
			end else if (it.cmd == CMD_PROGRAM &&
					(phase == SEQ_IDLE || phase == SEQ_WORD_READY)) begin
				// The first word of a payload fixes its address and its mode.
				if (phase == SEQ_IDLE) begin
					start_addr = it.address;
					word_addr = it.address;
					vpp = !it.test_write;
				end
				if (!vpp) begin
					if (it.last_word) begin
						add_op(KIND_DONE, 24'h000000, 16'h0000, 8'h00);
						dry_runs++;
						phase = SEQ_IDLE;
						final_word = 1'b0;
					end else begin
						word_addr = word_addr + 24'd2;
						phase = SEQ_WORD_READY;
					end
				end else begin
					add_op(KIND_WRITE, word_addr, FL_CLEAR_STATUS, 8'h00);
					add_op(KIND_WRITE, word_addr, FL_WORD_PROGRAM, 8'h00);
					add_op(KIND_WRITE, word_addr, it.data, 8'h00);
					add_op(KIND_WRITE, word_addr, FL_READ_STATUS, 8'h00);
					add_op(KIND_READ, word_addr, 16'h0000, 8'h00);
					final_word = it.last_word;
					polls = 0;
					phase = SEQ_WORD_POLL;
				end
			end else if (it.cmd == CMD_STATUS && phase == SEQ_ERASE_POLL) begin
				polls++;
				if (it.data[7] || limit_hit(int'(erase_limit))) begin
					if (it.data[7])
						erases_done++;
					else
						timeouts++;
					code = it.data[7:0] & ST_ERASE_MASK;
					if (code == ST_READY)
						code = 8'h00;
					finish_op(start_addr, code);
				end else begin
					add_op(KIND_READ, start_addr, 16'h0000, 8'h00);
				end
			end else if (it.cmd == CMD_STATUS && phase == SEQ_WORD_POLL) begin
				polls++;
				if (it.data[7]) begin
					if (final_word) begin
						code = ((it.data[7:0] & ST_PROGRAM_MASK) == ST_READY) ?
							8'h00 : it.data[7:0];
						programs_done++;
						finish_op(start_addr, code);
					end else begin
						word_addr = word_addr + 24'd2;
						polls = 0;
						phase = SEQ_WORD_READY;
					end
				end else if (limit_hit(int'(program_limit))) begin
					// A word timeout restores read-array mode at the stuck word.
					timeouts++;
					finish_op(word_addr, it.data[7:0]);
				end else begin
					add_op(KIND_READ, word_addr, 16'h0000, 8'h00);
				end
			end else begin
				taken = 1'b0;
				ignored++;
			end
			if (expected_bus_ops.size() > size_at_entry) begin
				tail_op = expected_bus_ops.pop_back();
				tail_op.last = 1'b1;
				expected_bus_ops.push_back(tail_op);
			end
			return taken;
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= MAX_PRINTED)
				$display("ERROR at %0t: %s", $time, msg);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		// Compares one accepted result with the oldest operation owed.
		task check_bus_op(bus_op_t got);
			bus_op_t want;
			checked++;
			if (expected_bus_ops.size() == 0) begin
				report($sformatf("unexpected result, kind %0h address %0h",
					got.kind, got.bus_address));
			end else begin
				want = expected_bus_ops.pop_front();
				compare_field("kind", 32'(got.kind), 32'(want.kind));
				compare_field("bus_address", 32'(got.bus_address), 32'(want.bus_address));
				compare_field("bus_data", 32'(got.bus_data), 32'(want.bus_data));
				compare_field("code", 32'(got.code), 32'(want.code));
				compare_field("vpp_enable", 32'(got.vpp_enable), 32'(want.vpp_enable));
				compare_field("last", 32'(got.last), 32'(want.last));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;  // address[23:0], data[39:24], test_write[40]
	logic [1:0]  s_axis_tuser = '0;  // cmd[1:0]
	logic        s_axis_tlast = 1'b0;  // last_word
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;  // bus_address[23:0], bus_data[39:24], code[47:40],
	                            // vpp_enable[48]
	logic [1:0]  m_axis_tuser;  // kind[1:0]
	logic        m_axis_tlast;  // last
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [22:0] cfg_data = '0;

	flash_sequence_predictor seq_pred = new();
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_off_req = 1'b0;
	int cycle_count = 0;

	flash_program_erase_sequencer_unit #(
		.ADDR_BITS(24)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle gaps: mostly none, some short, a few long.
	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	// Offers one request and waits until it is taken.
	task automatic send_request(input item_t it);
		int gap;
		gap = pick_gap(tx_idle_pct);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, it.test_write, it.data, it.address};
		s_axis_tuser <= it.cmd;
		s_axis_tlast <= it.last_word;
		do @(posedge clk); while (!s_axis_tready);
		void'(seq_pred.note_request(it));
	endtask

	task automatic send_fields(input logic [1:0] cmd, input logic [23:0] addr,
			input logic [15:0] data, input bit last_word, input bit test_write);
		item_t it;
		it.cmd = cmd;
		it.address = addr;
		it.data = data;
		it.last_word = last_word;
		it.test_write = test_write;
		send_request(it);
	endtask

	// A few busy status words, then one that is usually ready.
	task automatic send_status_replies(input bit want_ready);
		logic [31:0] rnd;
		int n;
		n = $urandom_range(0, 3);
		repeat (n) begin
			rnd = $urandom();
			send_fields(CMD_STATUS, rnd[31:8], rnd[15:0] & 16'hFF7F, rnd[24],
				rnd[25]);
		end
		rnd = $urandom();
		rnd[7] = want_ready;
		send_fields(CMD_STATUS, rnd[31:8], rnd[15:0], rnd[26], rnd[27]);
	endtask

	// A program payload; a truncated one never marks its last word.
	task automatic program_payload(input bit truncate);
		logic [31:0] rnd;
		logic [23:0] addr;
		int nwords;
		bit dry;
		nwords = $urandom_range(1, 4);
		dry = ($urandom_range(0, 3) == 0);
		rnd = $urandom();
		addr = ($urandom_range(0, 5) == 0) ? {21'h1FFFFF, rnd[2:0]} : rnd[23:0];
		for (int w = 0; w < nwords; w++) begin
			rnd = $urandom();
			send_fields(CMD_PROGRAM, (w == 0) ? addr : rnd[31:8], rnd[15:0],
				!truncate && (w == nwords - 1), (w == 0) ? dry : rnd[16]);
			if (!dry)
				send_status_replies($urandom_range(0, 4) != 0);
		end
	endtask

	// Random traffic for about the given number of requests.
	task automatic run_random(input int target);
		logic [31:0] rnd;
		int goal;
		int pick;
		goal = seq_pred.requests + target;
		while (seq_pred.requests < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				rnd = $urandom();
				send_fields(CMD_ERASE, rnd[23:0], rnd[31:16], rnd[24], rnd[25]);
				send_status_replies($urandom_range(0, 3) != 0);
			end else if (pick < 75) begin
				program_payload(1'b0);
			end else if (pick < 85) begin
				program_payload(1'b1);
			end else begin
				rnd = $urandom();
				send_fields(rnd[1:0], rnd[31:8], rnd[17:2], rnd[18], rnd[19]);
			end
			if ($urandom_range(0, 39) == 0)
				wait_for_bus_ops(0);
		end
	endtask

	// Stops offering requests until every owed result has arrived.
	task automatic wait_for_bus_ops(input int tail);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (seq_pred.expected_bus_ops.size() > 0);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [22:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		seq_pred.set_reg(index, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: check accepted results and stall at random.
	initial begin : result_sink
		bus_op_t got;
		int gap_left;
		int hold_left;
		gap_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				got.bus_address = m_axis_tdata[23:0];
				got.bus_data = m_axis_tdata[39:24];
				got.code = m_axis_tdata[47:40];
				got.vpp_enable = m_axis_tdata[48];
				got.last = m_axis_tlast;
				seq_pred.check_bus_op(got);
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (gap_left == 0)
					gap_left = pick_gap(rx_idle_pct);
				if (gap_left > 0) begin
					gap_left--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// Hard stop for a run that hangs.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
		$display("flash_program_erase_sequencer_unit: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] rnd;
		logic [22:0] erase_lim;
		logic [15:0] program_lim;
		int n_items;
		int p;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests with the reset poll limits.
		tx_idle_pct = 25;
		rx_idle_pct = 25;
		send_fields(CMD_STATUS, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1);
		send_fields(CMD_UNUSED, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1);
		// Erase ignores the dry-run flag; erase and program while busy are dropped.
		send_fields(CMD_ERASE, 24'h000000, 16'h0000, 1'b0, 1'b1);
		send_fields(CMD_ERASE, 24'h123456, 16'h0000, 1'b0, 1'b0);
		send_fields(CMD_PROGRAM, 24'h654321, 16'h1234, 1'b1, 1'b0);
		send_fields(CMD_STATUS, 24'h000000, 16'h0000, 1'b0, 1'b0);
		send_fields(CMD_STATUS, 24'h000000, 16'h0080, 1'b0, 1'b0);
		send_fields(CMD_ERASE, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b0);
		send_fields(CMD_STATUS, 24'h000000, 16'hFF7F, 1'b0, 1'b0);
		send_fields(CMD_STATUS, 24'h000000, 16'hFFFF, 1'b0, 1'b0);
		// Two-word payload whose word address wraps past the top.
		send_fields(CMD_PROGRAM, 24'hFFFFFE, 16'h0000, 1'b0, 1'b0);
		send_fields(CMD_ERASE, 24'h000010, 16'h0000, 1'b0, 1'b0);
		send_fields(CMD_PROGRAM, 24'h000020, 16'h5A5A, 1'b0, 1'b0);
		send_fields(CMD_STATUS, 24'h000000, 16'h0080, 1'b0, 1'b0);
		send_fields(CMD_PROGRAM, 24'h555555, 16'hFFFF, 1'b1, 1'b1);
		send_fields(CMD_STATUS, 24'h000000, 16'h0090, 1'b0, 1'b0);
		// Dry-run payload; later words cannot turn the voltage back on.
		send_fields(CMD_PROGRAM, 24'hABCDEF, 16'h1111, 1'b0, 1'b1);
		send_fields(CMD_PROGRAM, 24'h000000, 16'h2222, 1'b0, 1'b0);
		send_fields(CMD_STATUS, 24'h000000, 16'h0080, 1'b0, 1'b0);
		send_fields(CMD_PROGRAM, 24'h000000, 16'h3333, 1'b1, 1'b0);
		send_fields(CMD_PROGRAM, 24'h000100, 16'hA5A5, 1'b1, 1'b0);
		send_fields(CMD_STATUS, 24'h000000, 16'h0180, 1'b0, 1'b0);
		send_fields(CMD_PROGRAM, 24'h00ABCD, 16'h4444, 1'b1, 1'b1);
		send_fields(CMD_ERASE, 24'h7FFFFE, 16'h0000, 1'b0, 1'b0);
		send_fields(CMD_STATUS, 24'h000000, 16'h00A8, 1'b0, 1'b0);
		wait_for_bus_ops(TAIL_CYCLES);

		// Random phases, each under its own pair of poll limits.
		for (p = 0; p < 5; p++) begin
			case (p)
				0: begin
					erase_lim = 23'd1;
					program_lim = 16'd1;
					tx_idle_pct = 30;
					rx_idle_pct = 30;
					n_items = 90;
				end
				1: begin
					erase_lim = 23'd0;
					program_lim = 16'd0;
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					n_items = 60;
				end
				2: begin
					erase_lim = 23'h7FFFFF;
					program_lim = 16'hFFFF;
					tx_idle_pct = 40;
					rx_idle_pct = 50;
					n_items = 100;
				end
				3: begin
					erase_lim = 23'd3;
					program_lim = 16'd2;
					tx_idle_pct = 10;
					rx_idle_pct = 60;
					n_items = 100;
				end
				default: begin
					erase_lim = 23'd6;
					program_lim = 16'd5;
					tx_idle_pct = 50;
					rx_idle_pct = 10;
					n_items = 100;
				end
			endcase
			write_reg(REG_ERASE_LIMIT, erase_lim);
			write_reg(REG_PROGRAM_LIMIT, {7'd0, program_lim});
			if (p == 3) begin
				// Result side holds off while requests keep coming, then a full pause.
				hold_off_req = 1'b1;
				run_random(30);
				wait_for_bus_ops(0);
				run_random(n_items - 30);
			end else begin
				run_random(n_items);
			end
			// Bring the sequencer back to idle before the limits change.
			while (seq_pred.phase != SEQ_IDLE) begin
				rnd = $urandom();
				if (seq_pred.phase == SEQ_WORD_READY)
					send_fields(CMD_PROGRAM, 24'h000000, rnd[15:0], 1'b1, 1'b0);
				else
					send_fields(CMD_STATUS, 24'h000000, {8'h00, ST_READY}, 1'b0, 1'b0);
			end
			wait_for_bus_ops(TAIL_CYCLES);
		end

		$display("Sent %0d requests (%0d ignored), checked %0d results over six limit settings.",
			seq_pred.requests, seq_pred.ignored, seq_pred.checked);
		$display("Erases %0d, programs %0d, dry runs %0d, poll timeouts %0d.",
			seq_pred.erases_done, seq_pred.programs_done, seq_pred.dry_runs,
			seq_pred.timeouts);
		if (seq_pred.mismatches == 0)
			$display("flash_program_erase_sequencer_unit: match");
		else
			$display("flash_program_erase_sequencer_unit: mismatch");
		$finish;
	end

endmodule

### files.f
src/fpes_pkg.sv
src/fpes_ctrl.sv
src/fpes_emit.sv
src/flash_program_erase_sequencer_unit.sv
bench/testbench.sv
